// File: rtl/tiny_register_machine_executor_core_macros.svh
// Assertion macros shared by the executor RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef TINY_REGISTER_MACHINE_EXECUTOR_CORE_MACROS_SVH
`define TINY_REGISTER_MACHINE_EXECUTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked by clk_i, off while rst_ni is low
`define TRMX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("trmx: assertion failed");
// explicit clock and reset
`define TRMX_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("trmx: assertion failed");
`else
`define TRMX_ASSERT(lbl, prop)
`define TRMX_ASSERT_CLK(lbl, clk, rstn, prop)
`endif

`endif

// File: rtl/trmx_pkg.sv
// Shared constants and types of the register machine executor.
// No dependencies.
package trmx_pkg;

  localparam int TRMX_NUM_REGS   = 8;
  localparam int TRMX_PC_INDEX   = 7;
  localparam int TRMX_MEM_DEPTH  = 256;
  localparam int TRMX_DATA_WIDTH = 32;

  localparam int OP_W   = 4;
  localparam int REG_W  = 3;
  localparam int IMM_W  = 32;
  localparam int ADDR_W = 16;
  localparam int OUT_W  = 32;
  localparam int STAT_W = 3;
  localparam int PLEN_W = 16;
  localparam int MSIZE_W = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_NOOP  = 4'd0;
  localparam logic [OP_W-1:0] OP_PRINT = 4'd1;
  localparam logic [OP_W-1:0] OP_SET   = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd3;
  localparam logic [OP_W-1:0] OP_STORE = 4'd4;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd5;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd6;
  localparam logic [OP_W-1:0] OP_JGT   = 4'd7;
  localparam logic [OP_W-1:0] OP_JEQ   = 4'd8;
  localparam logic [OP_W-1:0] OP_JI    = 4'd9;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_MEM    = 3'd1;
  localparam logic [STAT_W-1:0] ST_JUMP   = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDEF  = 3'd3;
  localparam logic [STAT_W-1:0] ST_DONE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 1'b1;

  localparam logic [PLEN_W-1:0]  PROG_LEN_RST = 16'd1;
  localparam logic [MSIZE_W-1:0] MEM_SIZE_RST = 9'd256;

  // execute decisions handed to the commit logic
  typedef struct packed {
    logic              rf_we;
    logic              dm_we;
    logic              print_valid;
    logic [STAT_W-1:0] status;
  } trmx_ctl_t;

endpackage

// File: rtl/trmx_regfile.sv
// Register file: synchronous memory, one write port, two registered read ports.
// A last-write bypass covers a read issued on the edge of a write. Uses trmx_pkg.
module trmx_regfile import trmx_pkg::*; #(
  parameter int NUM_REGS   = TRMX_NUM_REGS,
  parameter int DATA_WIDTH = TRMX_DATA_WIDTH,
  localparam int RAW = $clog2(NUM_REGS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [RAW-1:0]        waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [RAW-1:0]        raddr_a_i,
  input  logic [RAW-1:0]        raddr_b_i,
  output logic [DATA_WIDTH-1:0] rdata_a_o,
  output logic [DATA_WIDTH-1:0] rdata_b_o
);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q, wb_data_q;
  logic [RAW-1:0]        ra_a_q, ra_b_q, wb_addr_q;
  logic                  wb_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem[raddr_a_i];
      rd_b_q <= mem[raddr_b_i];
      ra_a_q <= raddr_a_i;
      ra_b_q <= raddr_b_i;
    end
    if (we_i) begin
      wb_addr_q <= waddr_i;
      wb_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else if (we_i) begin
      wb_vld_q <= 1'b1;
    end
  end

  // latest write always matches memory contents, so the bypass is safe at any age
  assign rdata_a_o = (wb_vld_q && wb_addr_q == ra_a_q) ? wb_data_q : rd_a_q;
  assign rdata_b_o = (wb_vld_q && wb_addr_q == ra_b_q) ? wb_data_q : rd_b_q;

endmodule

// File: rtl/trmx_dmem.sv
// Data memory: synchronous single-port-write, registered read, last-write bypass.
// Uses trmx_pkg.
module trmx_dmem import trmx_pkg::*; #(
  parameter int MEM_DEPTH  = TRMX_MEM_DEPTH,
  parameter int DATA_WIDTH = TRMX_DATA_WIDTH,
  localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [MAW-1:0]        waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [MAW-1:0]        raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rd_q, wb_data_q;
  logic [MAW-1:0]        ra_q, wb_addr_q;
  logic                  wb_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
      wb_addr_q    <= waddr_i;
      wb_data_q    <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
      ra_q <= raddr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else if (we_i) begin
      wb_vld_q <= 1'b1;
    end
  end

  assign rdata_o = (wb_vld_q && wb_addr_q == ra_q) ? wb_data_q : rd_q;

endmodule

// File: rtl/trmx_exec.sv
// Execute stage: decodes one instruction with its operands and works out the
// register, memory and PC updates plus the status. Uses trmx_pkg.
module trmx_exec import trmx_pkg::*; #(
  parameter int NUM_REGS   = TRMX_NUM_REGS,
  parameter int PC_INDEX   = TRMX_PC_INDEX,
  parameter int MEM_DEPTH  = TRMX_MEM_DEPTH,
  parameter int DATA_WIDTH = TRMX_DATA_WIDTH
) (
  input  logic [OP_W-1:0]         op_i,
  input  logic [REG_W-1:0]        dst_i,
  input  logic signed [IMM_W-1:0] imm_i,
  input  logic [ADDR_W-1:0]       addr_i,
  input  logic [DATA_WIDTH-1:0]   a_i,
  input  logic [DATA_WIDTH-1:0]   b_i,
  input  logic [DATA_WIDTH-1:0]   m_i,
  input  logic [DATA_WIDTH-1:0]   pc_i,
  input  logic                    halt_i,
  input  logic [PLEN_W-1:0]       prog_len_i,
  input  logic [MSIZE_W-1:0]      mem_size_i,
  output trmx_ctl_t               ctl_o,
  output logic [DATA_WIDTH-1:0]   wdata_o,
  output logic [DATA_WIDTH-1:0]   pc_next_o
);

  localparam int  DW    = DATA_WIDTH;
  localparam int  CMPW  = (DW > PLEN_W) ? DW : PLEN_W;
  localparam int  MCW   = ADDR_W + 1;
  localparam bit  PC_EXISTS = (PC_INDEX < NUM_REGS);

  function automatic logic tgt_ok(logic [DW-1:0] v, logic [PLEN_W-1:0] pl);
    return !v[DW-1] && (CMPW'(v) < CMPW'(pl));
  endfunction

  logic [DW-1:0]     imm_x, wr_val, jt, pc_base, pc_new;
  logic              wr_en, jumped, addr_ok, dst_pc, dst_ok;
  logic [STAT_W-1:0] st;
  logic              pv;

  assign imm_x  = DW'(imm_i);
  assign addr_ok = (MCW'(addr_i) < MCW'(MEM_DEPTH)) && (MCW'(addr_i) < MCW'(mem_size_i));
  assign dst_ok = (32'(dst_i) < NUM_REGS);
  assign dst_pc = (32'(dst_i) == PC_INDEX);

  always_comb begin
    st      = ST_OK;
    pv      = 1'b0;
    wr_en   = 1'b0;
    wr_val  = '0;
    jumped  = 1'b0;
    jt      = '0;
    ctl_o   = '0;
    pc_base = pc_i;
    pc_new  = pc_i;
    if (halt_i) begin
      st = ST_DONE;
    end else begin
      unique case (op_i) inside
        OP_NOOP: ;
        OP_PRINT: pv = 1'b1;
        OP_SET: begin
          wr_en  = 1'b1;
          wr_val = imm_x;
        end
        OP_LOAD: begin
          if (!addr_ok) st = ST_MEM;
          else begin
            wr_en  = 1'b1;
            wr_val = m_i;
          end
        end
        OP_STORE: begin
          if (!addr_ok) st = ST_MEM;
          else ctl_o.dm_we = 1'b1;
        end
        OP_SUB: begin
          wr_en  = 1'b1;
          wr_val = a_i - b_i;
        end
        OP_ADD: begin
          wr_en  = 1'b1;
          wr_val = a_i + b_i;
        end
        OP_JGT, OP_JEQ: begin
          // the target is checked whether or not the branch is taken
          if (!tgt_ok(imm_x, prog_len_i)) st = ST_JUMP;
          else begin
            jt     = imm_x;
            jumped = (op_i == OP_JGT) ? ($signed(a_i) > $signed(b_i)) : (a_i == b_i);
          end
        end
        OP_JI: begin
          if (!tgt_ok(b_i, prog_len_i)) st = ST_JUMP;
          else begin
            jt     = b_i;
            jumped = 1'b1;
          end
        end
        default: st = ST_UNDEF;
      endcase

      if (st == ST_OK) begin
        ctl_o.rf_we = wr_en && dst_ok && !dst_pc;
        if (jumped) pc_base = jt;
        else if (wr_en && dst_ok && dst_pc) pc_base = wr_val;
        pc_new = !PC_EXISTS ? '0 : (jumped ? pc_base : pc_base + DW'(1));
        if (CMPW'(pc_new) == CMPW'(prog_len_i)) st = ST_DONE;
      end else begin
        ctl_o.dm_we = 1'b0;
      end
    end
    ctl_o.status      = st;
    ctl_o.print_valid = pv;
  end

  assign wdata_o   = wr_val;
  assign pc_next_o = pc_new;

endmodule

// File: rtl/tiny_register_machine_executor_core.sv
// Top level of the register machine executor: handshakes, PC/halt state,
// clearing pass and commit. Uses trmx_pkg, trmx_regfile, trmx_dmem, trmx_exec.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------
//  in      | input     | in_valid_i / in_ready_o     | opcode, src_reg, dst_reg, imm, addr
//  out     | output    | out_valid_o / out_ready_i   | next_pc, status, print_valid/value
//  cfg     | input     | cfg_we_i (no wait)          | cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the output is taken. An accepted item reads the register file
// and data memory on its accept edge, then executes and commits into the output register
// once that register is free. After reset a clearing pass zeroes both memories;
// in_ready_o stays low meanwhile.
// in_ready_o drops while an item waits in execute behind an output item that is not taken.
`include "tiny_register_machine_executor_core_macros.svh"

module tiny_register_machine_executor_core import trmx_pkg::*; #(
  parameter int NUM_REGS   = TRMX_NUM_REGS,
  parameter int PC_INDEX   = TRMX_PC_INDEX,
  parameter int MEM_DEPTH  = TRMX_MEM_DEPTH,
  parameter int DATA_WIDTH = TRMX_DATA_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic [REG_W-1:0]        src_reg_i,
  input  logic [REG_W-1:0]        dst_reg_i,
  input  logic signed [IMM_W-1:0] immediate_i,
  input  logic [ADDR_W-1:0]       mem_address_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] next_pc_o,
  output logic [STAT_W-1:0]       status_o,
  output logic                    print_valid_o,
  output logic signed [OUT_W-1:0] print_value_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int DW      = DATA_WIDTH;
  localparam int RAW     = $clog2(NUM_REGS);
  localparam int MAW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CLR_LEN = (MEM_DEPTH > NUM_REGS) ? MEM_DEPTH : NUM_REGS;
  localparam int CW      = $clog2(CLR_LEN);

  // configuration
  logic [PLEN_W-1:0]  prog_len_q;
  logic [MSIZE_W-1:0] mem_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= PROG_LEN_RST;
      mem_size_q <= MEM_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROG_LEN: prog_len_q <= cfg_wdata_i;
        CFG_MEM_SIZE: mem_size_q <= cfg_wdata_i[MSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clr_busy_q, clr_busy_d;
  logic [CW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + CW'(1);
      if (clr_cnt_q == CW'(CLR_LEN - 1)) clr_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // pipeline control
  logic s1_vld_q, o_vld_q, s1_go, in_fire, in_ready;

  assign s1_go      = s1_vld_q && (!o_vld_q || out_ready_i);
  assign in_ready   = !clr_busy_q && (!s1_vld_q || s1_go);
  assign in_fire    = in_valid_i && in_ready;
  assign in_ready_o = in_ready;

  logic [OP_W-1:0]         s1_op_q;
  logic [REG_W-1:0]        s1_src_q, s1_dst_q;
  logic signed [IMM_W-1:0] s1_imm_q;
  logic [ADDR_W-1:0]       s1_addr_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= opcode_i;
      s1_src_q  <= src_reg_i;
      s1_dst_q  <= dst_reg_i;
      s1_imm_q  <= immediate_i;
      s1_addr_q <= mem_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (in_fire) s1_vld_q <= 1'b1;
      else if (s1_go) s1_vld_q <= 1'b0;
      if (s1_go) o_vld_q <= 1'b1;
      else if (out_ready_i) o_vld_q <= 1'b0;
    end
  end

  // memories
  trmx_ctl_t       ex_ctl;
  logic [DW-1:0]   ex_wdata, ex_pc_next;
  logic [DW-1:0]   rf_rd_a, rf_rd_b, dm_rd, opa, opb;
  logic            rf_we, dm_we;
  logic [RAW-1:0]  rf_waddr;
  logic [MAW-1:0]  dm_waddr;
  logic [DW-1:0]   rf_wdata, dm_wdata;
  logic [DW-1:0]   pc_q, pc_d;
  logic            halt_q, halt_d;

  always_comb begin
    if (clr_busy_q) begin
      rf_we    = (32'(clr_cnt_q) < NUM_REGS);
      rf_waddr = RAW'(clr_cnt_q);
      rf_wdata = '0;
      dm_we    = (32'(clr_cnt_q) < MEM_DEPTH);
      dm_waddr = MAW'(clr_cnt_q);
      dm_wdata = '0;
    end else begin
      rf_we    = s1_go && ex_ctl.rf_we;
      rf_waddr = RAW'(s1_dst_q);
      rf_wdata = ex_wdata;
      dm_we    = s1_go && ex_ctl.dm_we;
      dm_waddr = MAW'(s1_addr_q);
      dm_wdata = opa;
    end
  end

  trmx_regfile #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .re_i      (in_fire),
    .raddr_a_i (RAW'(src_reg_i)),
    .raddr_b_i (RAW'(dst_reg_i)),
    .rdata_a_o (rf_rd_a),
    .rdata_b_o (rf_rd_b)
  );

  trmx_dmem #(
    .MEM_DEPTH  (MEM_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (in_fire),
    .raddr_i (MAW'(mem_address_i)),
    .rdata_o (dm_rd)
  );

  // operands: indexes past the file read zero, the PC lives in its own register
  assign opa = (32'(s1_src_q) >= NUM_REGS) ? '0 :
               (32'(s1_src_q) == PC_INDEX) ? pc_q : rf_rd_a;
  assign opb = (32'(s1_dst_q) >= NUM_REGS) ? '0 :
               (32'(s1_dst_q) == PC_INDEX) ? pc_q : rf_rd_b;

  trmx_exec #(
    .NUM_REGS   (NUM_REGS),
    .PC_INDEX   (PC_INDEX),
    .MEM_DEPTH  (MEM_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_exec (
    .op_i       (s1_op_q),
    .dst_i      (s1_dst_q),
    .imm_i      (s1_imm_q),
    .addr_i     (s1_addr_q),
    .a_i        (opa),
    .b_i        (opb),
    .m_i        (dm_rd),
    .pc_i       (pc_q),
    .halt_i     (halt_q),
    .prog_len_i (prog_len_q),
    .mem_size_i (mem_size_q),
    .ctl_o      (ex_ctl),
    .wdata_o    (ex_wdata),
    .pc_next_o  (ex_pc_next)
  );

  // commit
  assign pc_d   = s1_go ? ex_pc_next : pc_q;
  assign halt_d = halt_q || (s1_go && ex_ctl.status != ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      halt_q <= halt_d;
    end
  end

  logic [OUT_W-1:0]  o_pc_q, o_pval_q;
  logic [STAT_W-1:0] o_stat_q;
  logic              o_pv_q;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      o_pc_q   <= OUT_W'(ex_pc_next);
      o_stat_q <= ex_ctl.status;
      o_pv_q   <= ex_ctl.print_valid;
      o_pval_q <= ex_ctl.print_valid ? OUT_W'(opa) : '0;
    end
  end

  assign out_valid_o   = o_vld_q;
  assign next_pc_o     = o_pc_q;
  assign status_o      = o_stat_q;
  assign print_valid_o = o_pv_q;
  assign print_value_o = o_pval_q;

  `TRMX_ASSERT(a_halt_sticky, halt_q |=> halt_q)
  `TRMX_ASSERT(a_halted_no_change, (s1_go && halt_q) |-> (ex_ctl.status == ST_DONE && !ex_ctl.rf_we && !ex_ctl.dm_we && pc_d == pc_q))
  `TRMX_ASSERT(a_fault_halts, (s1_go && ex_ctl.status != ST_OK) |=> halt_q)
  `TRMX_ASSERT(a_fault_keeps_pc, (s1_go && ex_ctl.status != ST_OK && ex_ctl.status != ST_DONE) |-> (pc_d == pc_q && !ex_ctl.rf_we && !ex_ctl.dm_we))

endmodule
